FILE: hdl/qph_pkg.sv
package qph_pkg;

  // Operation carried with each request.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Outcome returned with each result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  localparam int unsigned ActionBits = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned InKeyBits  = 32;
  localparam int unsigned OutSlotBits = 4;

endpackage

FILE: hdl/qph_ram.sv
module qph_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/quadratic_probe_hash_table_top.sv
// Channel   Direction  Payload
// s_*       in         tuser: action; tdata: key
// m_*       out        tuser: status; tdata: slot
//
// After reset the table is swept empty, one slot per cycle, over every slot;
// no request is taken during that pass.
// A request reduces the key to its home slot (reciprocal multiply, multiply
// back and subtract, one conditional subtract), reads each probe through the
// registered read port of the slot memory and checks it, then posts the
// result; the unused action goes straight to posting its result.
// The input is not ready while a request runs, and a finished result waits in
// its state while the output is stalled.
module quadratic_probe_hash_table_top #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] s_tuser,   // [1:0] action
  input  logic [31:0] s_tdata,  // [31:0] key
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [1:0] m_tuser,   // [1:0] status
  output logic [7:0] m_tdata    // [3:0] slot, [7:4] zero
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EW = KEY_BITS + 1;
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(SLOTS));

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SUB,
    S_HOME,
    S_READ,
    S_CHECK,
    S_RESULT
  } state_t;

  state_t               state;
  logic [AW-1:0]        clr_addr;
  qph_pkg::action_t     action;
  logic [KEY_BITS-1:0]  key;
  logic [31:0]          quo_rem;
  logic [AW-1:0]        home;
  logic [AW-1:0]        offset;
  logic [AW-1:0]        step;
  logic [AW-1:0]        probe;
  logic [AW-1:0]        slot;
  qph_pkg::status_t     res_status;
  logic [AW-1:0]        res_slot;

  logic [31:0]          key_lo;
  logic [63:0]          recip_prod;
  logic [31:0]          back_prod;
  logic [31:0]          home_diff;
  logic [AW-1:0]        home_next;
  logic [AW:0]          addr_sum;
  logic [AW-1:0]        probe_addr;
  logic [AW:0]          off_sum;
  logic [AW-1:0]        offset_next;
  logic [AW:0]          step_sum;
  logic [AW-1:0]        step_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic                 ram_re;
  logic [EW-1:0]        ram_rdata;
  logic                 rd_valid;
  logic                 rd_match;
  logic                 last_probe;

  // The key never carries more than 32 significant bits. The quotient estimate
  // from the truncated reciprocal is low by at most one, so the remainder
  // left after multiplying back is below 2*SLOTS and one subtract finishes it.
  assign key_lo     = 32'(key);
  assign recip_prod = 64'(key_lo) * 64'(RECIP);
  assign back_prod  = quo_rem * SLOTS_W;
  assign home_diff  = key_lo - back_prod;
  assign home_next  = (quo_rem >= SLOTS_W) ? AW'(quo_rem - SLOTS_W) : AW'(quo_rem);

  // Slot of the current probe: home plus i*i, both already below SLOTS.
  assign addr_sum   = {1'b0, home} + {1'b0, offset};
  assign probe_addr = (addr_sum >= (AW+1)'(SLOTS)) ?
                      AW'(addr_sum - (AW+1)'(SLOTS)) : AW'(addr_sum);

  // (i+1)^2 = i^2 + (2i+1); both terms are kept reduced modulo SLOTS.
  assign off_sum     = {1'b0, offset} + {1'b0, step};
  assign offset_next = (off_sum >= (AW+1)'(SLOTS)) ?
                       AW'(off_sum - (AW+1)'(SLOTS)) : AW'(off_sum);
  assign step_sum    = {1'b0, step} + (AW+1)'(2);
  assign step_next   = (step_sum >= (AW+1)'(SLOTS)) ?
                       AW'(step_sum - (AW+1)'(SLOTS)) : AW'(step_sum);

  assign rd_valid   = ram_rdata[KEY_BITS];
  assign rd_match   = (ram_rdata[KEY_BITS-1:0] == key);
  assign last_probe = (probe == AW'(SLOTS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = {1'b1, key};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_CHECK) begin
      if (action == qph_pkg::ACT_INSERT && !rd_valid) begin
        ram_we = 1'b1;
      end else if (action == qph_pkg::ACT_DELETE && rd_valid && rd_match) begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, key};
      end
    end
  end

  assign ram_re   = (state == S_READ);
  assign s_tready = (state == S_IDLE);

  qph_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(probe_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_RESULT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            action <= qph_pkg::action_t'(s_tuser);
            key    <= KEY_BITS'(s_tdata);
            if (s_tuser inside {qph_pkg::ACT_INSERT, qph_pkg::ACT_DELETE,
                                qph_pkg::ACT_SEARCH}) begin
              state <= S_MUL;
            end else begin
              res_status <= qph_pkg::ST_MISSING;
              res_slot   <= '0;
              state      <= S_RESULT;
            end
          end
        end
        S_MUL: begin
          quo_rem <= recip_prod[63:32];
          state   <= S_SUB;
        end
        S_SUB: begin
          quo_rem <= home_diff;
          state   <= S_HOME;
        end
        S_HOME: begin
          home   <= home_next;
          offset <= '0;
          step   <= AW'(1);
          probe  <= '0;
          state  <= S_READ;
        end
        S_READ: begin
          slot  <= probe_addr;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (action == qph_pkg::ACT_INSERT) begin
            if (!rd_valid) begin
              res_status <= qph_pkg::ST_OK;
              res_slot   <= slot;
              state      <= S_RESULT;
            end else if (last_probe) begin
              res_status <= qph_pkg::ST_FULL;
              res_slot   <= '0;
              state      <= S_RESULT;
            end else begin
              offset <= offset_next;
              step   <= step_next;
              probe  <= probe + AW'(1);
              state  <= S_READ;
            end
          end else begin
            // An empty slot ends the walk for delete and search.
            if (!rd_valid || (!rd_match && last_probe)) begin
              res_status <= qph_pkg::ST_MISSING;
              res_slot   <= '0;
              state      <= S_RESULT;
            end else if (rd_match) begin
              res_status <= qph_pkg::ST_OK;
              res_slot   <= slot;
              state      <= S_RESULT;
            end else begin
              offset <= offset_next;
              step   <= step_next;
              probe  <= probe + AW'(1);
              state  <= S_READ;
            end
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'b0000, qph_pkg::OutSlotBits'(res_slot)};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
